// ===== hdl/mlp_online_backprop_step_macros.svh =====
// Assertion macros for the network block. Both take a label, a condition and a consequent,
// sampled on the rising edge of clock and switched off while reset is high.
`ifndef MLP_ONLINE_BACKPROP_STEP_MACROS_SVH
`define MLP_ONLINE_BACKPROP_STEP_MACROS_SVH
`ifndef SYNTHESIS
// consequent checked in the same cycle
`define MLP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlp_obp: check failed");
// consequent checked in the cycle after the condition
`define MLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlp_obp: check failed");
`else
`define MLP_ASSERT_NOW(label, ante, cons)
`define MLP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/mlp_obp_pkg.sv =====
`default_nettype none

package mlp_obp_pkg;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_TRAIN = 2'd0,
      REQ_INFER = 2'd1,
      REQ_LOAD  = 2'd2,
      REQ_READ  = 2'd3
   } req_code_type;

   // fixed field widths
   localparam int IN_BITS   = 16;  // network inputs, Q4.12
   localparam int TGT_BITS  = 13;  // target and output, Q1.12
   localparam int WIDX_BITS = 5;
   localparam int WVAL_BITS = 24;  // loaded and read weights, Q8.16
   localparam int DO_BITS   = 16;  // output error term
   localparam int MB_BITS   = 24;  // second multiplier operand

   localparam logic [TGT_BITS-1:0] ONE_Q12 = 13'd4096;

   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 40;

endpackage

`default_nettype wire

// ===== hdl/mlp_obp_ram.sv =====
`default_nettype none

module mlp_obp_ram #(
   parameter int DATA_BITS = 24,
   parameter int DEPTH     = 17
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0]                      wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [DATA_BITS-1:0]                      rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/mlp_online_backprop_step.sv =====
`default_nettype none
// 2-input, 4-hidden, 1-output sigmoid network with online backprop, one item at a time.
// A train beat runs the forward pass, applies one gradient step (learning rate 1,
// derivative y*(1-y)) and then returns the output of that forward pass; an infer beat runs
// the forward pass only; load and read beats reach single weights (0-7 hidden weights,
// 8-11 hidden biases, 12-15 output weights, 16 output bias). The multiplies go through one
// shared 26x24 multiplier and the weight updates through one saturating adder under a
// sequencer, with the weights in a small RAM read one entry per cycle. req_tready is low
// while an item is in work; one finished result may wait in the output register while the
// next item is taken. Weights are zero after reset.
`include "mlp_online_backprop_step_macros.svh"

module mlp_online_backprop_step #(
   parameter int HIDDEN_UNITS    = 4,
   parameter int NET_INPUTS      = 2,
   parameter int SIGMOID_ENTRIES = 256,
   parameter int WEIGHT_BITS     = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // in_a, in_b, target, weight_index, weight_value, zero pad
   input  wire logic [mlp_obp_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_type
   input  wire logic [1:0]                             req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // net_output, weight_read, zero pad
   output logic      [mlp_obp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   localparam int HB_BASE     = HIDDEN_UNITS * NET_INPUTS;
   localparam int OW_BASE     = HB_BASE + HIDDEN_UNITS;
   localparam int OB_INDEX    = OW_BASE + HIDDEN_UNITS;
   localparam int NUM_WEIGHTS = OB_INDEX + 1;
   localparam int AW          = $clog2(NUM_WEIGHTS);
   localparam int HW          = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
   localparam int NW          = (NET_INPUTS > 1) ? $clog2(NET_INPUTS) : 1;
   localparam int IDX_BITS    = $clog2(SIGMOID_ENTRIES);
   localparam int EB          = $clog2(SIGMOID_ENTRIES + 1);
   localparam int MA          = WEIGHT_BITS + 2;
   localparam int MB          = mlp_obp_pkg::MB_BITS;
   localparam int PB          = MA + MB;
   localparam int ACC_BITS    = WEIGHT_BITS + 19;
   localparam int ZB          = WEIGHT_BITS + 8;
   localparam int SUM_BITS    = WEIGHT_BITS + 15;
   localparam int TB          = mlp_obp_pkg::TGT_BITS;
   localparam int IB          = mlp_obp_pkg::IN_BITS;
   localparam longint WMAX    = (longint'(1) << (WEIGHT_BITS - 1)) - 1;
   localparam longint WMIN    = -WMAX - 1;
   localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'(WMAX);
   localparam logic signed [SUM_BITS-1:0] SAT_LO = SUM_BITS'(WMIN);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_RREQ, ST_RDAT,
      ST_F_RD, ST_F_MUL, ST_F_ACC, ST_B_RD, ST_B_ADD, ST_S_IDX, ST_S_LUT,
      ST_O_RD, ST_O_MUL, ST_O_ACC,
      ST_D1, ST_D2, ST_D3,
      ST_U_RD, ST_U_MUL, ST_U_WV, ST_U_P, ST_U_DH1, ST_U_DH2,
      ST_W_RD, ST_W_MUL, ST_W_WR, ST_HB_RD, ST_HB_WR, ST_OB_RD, ST_OB_WR,
      ST_DONE
   } st_type;

   // sigmoid table, built at elaboration by the integer exp series
   logic [TB-1:0] sig_lut [SIGMOID_ENTRIES];

   for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_sig
      localparam longint ONE = longint'(1) << 30;
      localparam longint Z   = ((longint'(k) << 34) / SIGMOID_ENTRIES) - (longint'(8) << 30);
      localparam longint T   = (Z >= 0) ? Z : -Z;
      localparam longint U   = T >> 4;
      localparam longint T1  = ((ONE * U) >> 30) / 1;
      localparam longint T2  = ((T1 * U) >> 30) / 2;
      localparam longint T3  = ((T2 * U) >> 30) / 3;
      localparam longint T4  = ((T3 * U) >> 30) / 4;
      localparam longint T5  = ((T4 * U) >> 30) / 5;
      localparam longint T6  = ((T5 * U) >> 30) / 6;
      localparam longint T7  = ((T6 * U) >> 30) / 7;
      localparam longint T8  = ((T7 * U) >> 30) / 8;
      localparam longint T9  = ((T8 * U) >> 30) / 9;
      localparam longint T10 = ((T9 * U) >> 30) / 10;
      localparam longint T11 = ((T10 * U) >> 30) / 11;
      localparam longint T12 = ((T11 * U) >> 30) / 12;
      localparam longint T13 = ((T12 * U) >> 30) / 13;
      localparam longint T14 = ((T13 * U) >> 30) / 14;
      localparam longint S0  = ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10
                               - T11 + T12 - T13 + T14;
      localparam longint S1  = (S0 * S0) >> 30;
      localparam longint S2  = (S1 * S1) >> 30;
      localparam longint S3  = (S2 * S2) >> 30;
      localparam longint S4  = (S3 * S3) >> 30;
      localparam longint DEN = ONE + S4;
      localparam longint NUM = (Z >= 0) ? (longint'(1) << 42) : (S4 << 12);
      localparam longint VAL = (NUM + DEN / 2) / DEN;
      assign sig_lut[k] = TB'(VAL);
   end

   // registers
   st_type                          state_ff, state_in;
   mlp_obp_pkg::req_code_type       op_ff, op_in;
   logic signed [IB-1:0]            x_ff [NET_INPUTS];
   logic signed [IB-1:0]            x_in [NET_INPUTS];
   logic [TB-1:0]                   tgt_ff, tgt_in;
   logic [mlp_obp_pkg::WIDX_BITS-1:0] widx_ff, widx_in;
   logic signed [mlp_obp_pkg::WVAL_BITS-1:0] wval_ff, wval_in;
   logic [HW-1:0]                   h_ff, h_in;
   logic [NW-1:0]                   i_ff, i_in;
   logic                            out_ph_ff, out_ph_in;
   logic signed [ACC_BITS-1:0]      acc_ff, acc_in;
   logic signed [ZB-1:0]            z_ff, z_in;
   logic [IDX_BITS-1:0]             sidx_ff, sidx_in;
   logic [TB-1:0]                   hv_ff [HIDDEN_UNITS];
   logic [TB-1:0]                   hv_in [HIDDEN_UNITS];
   logic [TB-1:0]                   y_ff, y_in;
   logic signed [mlp_obp_pkg::DO_BITS-1:0] do_ff, do_in;
   logic signed [MA-1:0]            p_ff, p_in;
   logic signed [MA-1:0]            dh_ff, dh_in;
   logic signed [PB-1:0]            prod_ff;
   logic [23:0]                     wres_ff, wres_in;
   logic [AW-1:0]                   raddr_ff, raddr_in;
   logic [NUM_WEIGHTS-1:0]          valid_ff, valid_in;
   logic                            rd_ok_ff, rd_ok_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [TB-1:0]                   rsp_net_ff, rsp_net_in;
   logic [23:0]                     rsp_weight_ff, rsp_weight_in;

   // datapath nets
   logic                            req_fire;
   logic                            in_range;
   logic                            h_last, i_last;
   logic                            rd_en, wr_en;
   logic [AW-1:0]                   rd_addr, wr_addr;
   logic [WEIGHT_BITS-1:0]          ram_q, wr_data;
   logic signed [WEIGHT_BITS-1:0]   q;
   logic signed [MA-1:0]            mul_a;
   logic signed [MB-1:0]            mul_b;
   logic signed [PB-1:0]            mul_p;
   logic signed [PB-13:0]           prod_sh12;
   logic signed [ACC_BITS-13:0]     acc_sh12;
   logic signed [SUM_BITS-1:0]      upd_base, upd_add, upd_sum;
   logic signed [TB:0]              err;
   logic signed [ZB:0]              sig_off;
   logic [19+EB:0]                  sig_mul;

   assign req_fire  = req_tvalid && req_tready;
   assign in_range  = 32'(widx_ff) < NUM_WEIGHTS;
   assign h_last    = h_ff == HW'(HIDDEN_UNITS - 1);
   assign i_last    = i_ff == NW'(NET_INPUTS - 1);
   assign q         = rd_ok_ff ? $signed(ram_q) : '0;
   assign prod_sh12 = prod_ff[PB-1:12];
   assign acc_sh12  = acc_ff[ACC_BITS-1:12];
   assign err       = $signed({1'b0, tgt_ff}) - $signed({1'b0, y_ff});
   assign sig_off   = (ZB+1)'(z_ff) + (ZB+1)'(524288);
   assign sig_mul   = sig_off[19:0] * EB'(SIGMOID_ENTRIES);

   // shared multiplier
   assign mul_p = mul_a * mul_b;

   // shared update adder with saturation to the weight range
   assign upd_sum = upd_base + upd_add;
   always_comb begin
      if (upd_sum > SAT_HI) begin
         wr_data = WEIGHT_BITS'(SAT_HI);
      end else if (upd_sum < SAT_LO) begin
         wr_data = WEIGHT_BITS'(SAT_LO);
      end else begin
         wr_data = WEIGHT_BITS'(upd_sum);
      end
   end

   assign wr_addr = (state_ff == ST_LOAD) ? AW'(widx_ff) : raddr_ff;

   mlp_obp_ram #(
      .DATA_BITS (WEIGHT_BITS),
      .DEPTH     (NUM_WEIGHTS)
   ) u_wram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      x_in          = x_ff;
      tgt_in        = tgt_ff;
      widx_in       = widx_ff;
      wval_in       = wval_ff;
      h_in          = h_ff;
      i_in          = i_ff;
      out_ph_in     = out_ph_ff;
      acc_in        = acc_ff;
      z_in          = z_ff;
      sidx_in       = sidx_ff;
      hv_in         = hv_ff;
      y_in          = y_ff;
      do_in         = do_ff;
      p_in          = p_ff;
      dh_in         = dh_ff;
      wres_in       = wres_ff;
      raddr_in      = raddr_ff;
      valid_in      = valid_ff;
      rd_ok_in      = rd_ok_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_net_in    = rsp_net_ff;
      rsp_weight_in = rsp_weight_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      upd_base      = SUM_BITS'(q);
      upd_add       = '0;

      // result beat taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = mlp_obp_pkg::req_code_type'(req_tuser);
               for (int n = 0; n < NET_INPUTS; n++) begin
                  x_in[n] = (n == 0) ? $signed(req_tdata[15:0]) :
                            ((n == 1) ? $signed(req_tdata[31:16]) : '0);
               end
               tgt_in  = (req_tdata[44:32] > mlp_obp_pkg::ONE_Q12) ? mlp_obp_pkg::ONE_Q12
                                                                   : req_tdata[44:32];
               widx_in = req_tdata[49:45];
               wval_in = $signed(req_tdata[73:50]);
               h_in    = '0;
               i_in    = '0;
               out_ph_in = 1'b0;
               acc_in  = '0;
               wres_in = '0;
               case (mlp_obp_pkg::req_code_type'(req_tuser))
                  mlp_obp_pkg::REQ_LOAD: state_in = ST_LOAD;
                  mlp_obp_pkg::REQ_READ: state_in = ST_RREQ;
                  default:               state_in = ST_F_RD;
               endcase
            end
         end
         ST_LOAD: begin
            upd_base = SUM_BITS'(wval_ff);
            wr_en    = in_range;
            state_in = ST_DONE;
         end
         ST_RREQ: begin
            rd_en    = in_range;
            rd_addr  = AW'(widx_ff);
            state_in = ST_RDAT;
         end
         ST_RDAT: begin
            wres_in  = in_range ? 24'(q) : '0;
            state_in = ST_DONE;
         end
         // hidden unit: multiply-accumulate over the inputs
         ST_F_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(h_ff * NET_INPUTS + i_ff);
            state_in = ST_F_MUL;
         end
         ST_F_MUL: begin
            mul_a    = MA'(q);
            mul_b    = MB'(x_ff[i_ff]);
            state_in = ST_F_ACC;
         end
         ST_F_ACC: begin
            acc_in = acc_ff + prod_ff[ACC_BITS-1:0];
            if (i_last) begin
               i_in     = '0;
               state_in = ST_B_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_F_RD;
            end
         end
         // bias, then sigmoid
         ST_B_RD: begin
            rd_en    = 1'b1;
            rd_addr  = out_ph_ff ? AW'(OB_INDEX) : AW'(HB_BASE + h_ff);
            state_in = ST_B_ADD;
         end
         ST_B_ADD: begin
            z_in     = ZB'(acc_sh12) + ZB'(q);
            state_in = ST_S_IDX;
         end
         ST_S_IDX: begin
            if (sig_off[ZB]) begin
               sidx_in = '0;
            end else if (|sig_off[ZB-1:20]) begin
               sidx_in = IDX_BITS'(SIGMOID_ENTRIES - 1);
            end else begin
               sidx_in = sig_mul[19+IDX_BITS:20];
            end
            state_in = ST_S_LUT;
         end
         ST_S_LUT: begin
            acc_in = '0;
            if (out_ph_ff) begin
               y_in     = sig_lut[sidx_ff];
               state_in = (op_ff == mlp_obp_pkg::REQ_INFER) ? ST_DONE : ST_D1;
            end else begin
               hv_in[h_ff] = sig_lut[sidx_ff];
               if (h_last) begin
                  h_in      = '0;
                  out_ph_in = 1'b1;
                  state_in  = ST_O_RD;
               end else begin
                  h_in     = h_ff + 1'b1;
                  state_in = ST_F_RD;
               end
            end
         end
         // output unit: multiply-accumulate over the hidden outputs
         ST_O_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(OW_BASE + h_ff);
            state_in = ST_O_MUL;
         end
         ST_O_MUL: begin
            mul_a    = MA'(q);
            mul_b    = MB'(hv_ff[h_ff]);
            state_in = ST_O_ACC;
         end
         ST_O_ACC: begin
            acc_in = acc_ff + prod_ff[ACC_BITS-1:0];
            if (h_last) begin
               h_in     = '0;
               state_in = ST_B_RD;
            end else begin
               h_in     = h_ff + 1'b1;
               state_in = ST_O_RD;
            end
         end
         // output error: y*(1-y)*(target-y)
         ST_D1: begin
            mul_a    = MA'(y_ff);
            mul_b    = MB'(mlp_obp_pkg::ONE_Q12 - y_ff);
            state_in = ST_D2;
         end
         ST_D2: begin
            mul_a    = MA'(err);
            mul_b    = prod_ff[MB-1:0];
            state_in = ST_D3;
         end
         ST_D3: begin
            do_in    = prod_ff[mlp_obp_pkg::DO_BITS+19:20];
            h_in     = '0;
            state_in = ST_U_RD;
         end
         // per hidden unit: output weight update, then hidden error
         ST_U_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(OW_BASE + h_ff);
            state_in = ST_U_MUL;
         end
         ST_U_MUL: begin
            mul_a    = MA'(do_ff);
            mul_b    = MB'(hv_ff[h_ff]);
            state_in = ST_U_WV;
         end
         ST_U_WV: begin
            upd_add  = SUM_BITS'(prod_sh12);
            wr_en    = 1'b1;
            mul_a    = MA'(q);
            mul_b    = MB'(do_ff);
            state_in = ST_U_P;
         end
         ST_U_P: begin
            p_in     = prod_ff[MA+15:16];
            mul_a    = MA'(hv_ff[h_ff]);
            mul_b    = MB'(mlp_obp_pkg::ONE_Q12 - hv_ff[h_ff]);
            state_in = ST_U_DH1;
         end
         ST_U_DH1: begin
            mul_a    = p_ff;
            mul_b    = prod_ff[MB-1:0];
            state_in = ST_U_DH2;
         end
         ST_U_DH2: begin
            dh_in    = prod_ff[PB-1:24];
            i_in     = '0;
            state_in = ST_W_RD;
         end
         // hidden weights of this unit
         ST_W_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(h_ff * NET_INPUTS + i_ff);
            state_in = ST_W_MUL;
         end
         ST_W_MUL: begin
            mul_a    = dh_ff;
            mul_b    = MB'(x_ff[i_ff]);
            state_in = ST_W_WR;
         end
         ST_W_WR: begin
            upd_add = SUM_BITS'(prod_sh12);
            wr_en   = 1'b1;
            if (i_last) begin
               i_in     = '0;
               state_in = ST_HB_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_W_RD;
            end
         end
         ST_HB_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(HB_BASE + h_ff);
            state_in = ST_HB_WR;
         end
         ST_HB_WR: begin
            upd_add = SUM_BITS'(dh_ff);
            wr_en   = 1'b1;
            if (h_last) begin
               state_in = ST_OB_RD;
            end else begin
               h_in     = h_ff + 1'b1;
               state_in = ST_U_RD;
            end
         end
         ST_OB_RD: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(OB_INDEX);
            state_in = ST_OB_WR;
         end
         ST_OB_WR: begin
            upd_add  = SUM_BITS'(do_ff);
            wr_en    = 1'b1;
            state_in = ST_DONE;
         end
         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_net_in    = (op_ff == mlp_obp_pkg::REQ_TRAIN ||
                                op_ff == mlp_obp_pkg::REQ_INFER) ? y_ff : '0;
               rsp_weight_in = wres_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // read side bookkeeping and written-entry marks
      if (rd_en) begin
         raddr_in = rd_addr;
         rd_ok_in = valid_ff[rd_addr];
      end
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      x_ff          <= x_in;
      tgt_ff        <= tgt_in;
      widx_ff       <= widx_in;
      wval_ff       <= wval_in;
      h_ff          <= h_in;
      i_ff          <= i_in;
      out_ph_ff     <= out_ph_in;
      acc_ff        <= acc_in;
      z_ff          <= z_in;
      sidx_ff       <= sidx_in;
      hv_ff         <= hv_in;
      y_ff          <= y_in;
      do_ff         <= do_in;
      p_ff          <= p_in;
      dh_ff         <= dh_in;
      prod_ff       <= mul_p;
      wres_ff       <= wres_in;
      raddr_ff      <= raddr_in;
      rsp_net_ff    <= rsp_net_in;
      rsp_weight_ff <= rsp_weight_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_weight_ff, rsp_net_ff};

   // checks
   `MLP_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `MLP_ASSERT_NOW(a_write_only_train_load, wr_en, (op_ff == mlp_obp_pkg::REQ_TRAIN) || (op_ff == mlp_obp_pkg::REQ_LOAD))
   `MLP_ASSERT_NEXT(a_result_issued, (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready), rsp_tvalid && req_tready)

endmodule

`default_nettype wire
